/* rtl/core/fid_pkg.sv */
// ----------------------------------------------------------------------------
// fid_pkg
// Shared types and constants for the fault injection decider.
// ----------------------------------------------------------------------------
package fid_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned DIVISOR_WIDTH   = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAIL_PERCENT   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EVERY_NTH      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAIL_BUDGET    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPACE_BUDGET   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_BY_TASK = 3'd4;

   localparam logic [DIVISOR_WIDTH-1:0] PERCENT_BASE     = 32'd100;
   localparam logic [31:0]              BUDGET_UNLIMITED = 32'hFFFF_FFFF;

   // floor(x / 100) = (x * PERCENT_RECIP) >> PERCENT_SHIFT for any 32-bit x
   localparam logic [31:0]              PERCENT_RECIP    = 32'h51EB_851F;
   localparam int unsigned              PERCENT_SHIFT    = 37;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

endpackage

/* rtl/core/fid_rem_unit.sv */
// ----------------------------------------------------------------------------
// fid_rem_unit
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fid_rem_unit #(
   parameter int unsigned DIVIDEND_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [DIVIDEND_WIDTH-1:0]           dividend,
   input  logic [fid_pkg::DIVISOR_WIDTH-1:0]   divisor,
   output logic [fid_pkg::DIVISOR_WIDTH-1:0]   remainder,
   output fid_pkg::rem_status_type             status
);
   import fid_pkg::*;

   localparam int unsigned STEP_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

   logic [STEP_WIDTH-1:0]      step_ff, step_in;
   logic                       done_ff, done_in;
   logic [DIVIDEND_WIDTH-1:0]  dividend_ff, dividend_in;
   logic [DIVISOR_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]     rem_ff, rem_in;
   logic [DIVISOR_WIDTH:0]     shifted;
   logic [DIVISOR_WIDTH:0]     divisor_ext;

   assign shifted     = {rem_ff[DIVISOR_WIDTH-1:0], dividend_ff[DIVIDEND_WIDTH-1]};
   assign divisor_ext = {1'b0, divisor_ff};

   always_comb begin
      step_in     = step_ff;
      done_in     = 1'b0;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (start) begin
         step_in     = STEP_WIDTH'(DIVIDEND_WIDTH);
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (step_ff != '0) begin
         step_in     = step_ff - STEP_WIDTH'(1);
         dividend_in = {dividend_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         rem_in      = (shifted >= divisor_ext) ? (shifted - divisor_ext) : shifted;
         done_in     = (step_ff == STEP_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign remainder   = rem_ff[DIVISOR_WIDTH-1:0];
   assign status.busy = (step_ff != '0);
   assign status.done = done_ff;

endmodule

/* rtl/core/fault_injection_decider_top.sv */
// ----------------------------------------------------------------------------
// fault_injection_decider_top
// Decides per request whether to force a failure, from filter, budgets,
// interval and percentage registers.
// ----------------------------------------------------------------------------
// One request at a time. A request that passes on the task filter, the
// failure budget or the space budget goes from the check state straight to
// the finish state. One that goes straight to the percentage check (interval
// of 0 or 1) waits in ST_WAIT_RND while random_word modulo 100 comes from a
// two-stage reciprocal multiply. One that reaches the interval check runs the
// counter modulo every_nth through a single bit-serial remainder unit, one
// bit per cycle over DW dividend bits, where DW is the larger of COUNT_WIDTH
// and 32. req_ready is high whenever no request is in work; a finished
// result waits in an output register and does not hold off the next
// request. Configuration writes are always taken; writing the failure
// or space budget also loads the running count.
module fault_injection_decider_top #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [30:0]                           req_request_size,
   input  logic                                  req_caller_eligible,
   input  logic                                  req_from_interrupt,
   input  logic [31:0]                           req_random_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_inject_fault,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fid_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fid_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import fid_pkg::*;

   localparam int unsigned DW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CHECK    = 3'd1;
   localparam logic [2:0] ST_WAIT_CNT = 3'd2;
   localparam logic [2:0] ST_WAIT_RND = 3'd3;
   localparam logic [2:0] ST_FINISH   = 3'd4;
   localparam logic [2:0] ST_PERCENT  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [6:0]             fail_percent_ff, fail_percent_in;
   logic [31:0]            every_nth_ff, every_nth_in;
   logic                   filter_ff, filter_in;
   logic [31:0]            failures_left_ff, failures_left_in;
   logic [30:0]            space_left_ff, space_left_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_fault_ff, rsp_fault_in;
   logic                   result_ff, result_in;
   logic [30:0]            size_ff;
   logic                   eligible_ff;
   logic                   irq_ff;
   logic [31:0]            rnd_ff;
   logic [6:0]             rnd_quot_ff;
   logic [6:0]             rnd_mod_ff;

   logic                   rem_start;
   logic [DW-1:0]          rem_dividend;
   logic [DIVISOR_WIDTH-1:0] rem_divisor;
   logic [DIVISOR_WIDTH-1:0] rem_value;
   rem_status_type         rem_status;
   logic                   csr_write;
   logic                   req_accept;
   logic [COUNT_WIDTH-1:0] counter_next;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign counter_next = counter_ff + COUNT_WIDTH'(1);

   fid_rem_unit #(
      .DIVIDEND_WIDTH (DW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .remainder (rem_value),
      .status    (rem_status)
   );

   always_comb begin
      state_in         = state_ff;
      fail_percent_in  = fail_percent_ff;
      every_nth_in     = every_nth_ff;
      filter_in        = filter_ff;
      failures_left_in = failures_left_ff;
      space_left_in    = space_left_ff;
      counter_in       = counter_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_fault_in     = rsp_fault_ff;
      result_in        = result_ff;
      rem_start        = 1'b0;
      rem_dividend     = DW'(counter_next);
      rem_divisor      = every_nth_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            result_in = 1'b0;
            if ((filter_ff && !(eligible_ff && !irq_ff)) || (failures_left_ff == '0)) begin
               state_in = ST_FINISH;
            end else if (space_left_ff > size_ff) begin
               space_left_in = space_left_ff - size_ff;
               state_in      = ST_FINISH;
            end else if (every_nth_ff > 32'd1) begin
               counter_in   = counter_next;
               rem_start    = 1'b1;
               state_in     = ST_WAIT_CNT;
            end else begin
               state_in  = ST_WAIT_RND;
            end
         end
         ST_WAIT_CNT: begin
            if (rem_status.done) begin
               if (rem_value != '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_PERCENT;
               end
            end
         end
         ST_WAIT_RND: begin
            state_in = ST_PERCENT;
         end
         ST_PERCENT: begin
            if (fail_percent_ff > rnd_mod_ff) begin
               result_in = 1'b1;
               if (failures_left_ff != BUDGET_UNLIMITED) begin
                  failures_left_in = failures_left_ff - 32'd1;
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_fault_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            CSR_FAIL_PERCENT:   fail_percent_in = csr_data[6:0];
            CSR_EVERY_NTH:      every_nth_in    = csr_data;
            CSR_FAIL_BUDGET:    failures_left_in = csr_data;
            CSR_SPACE_BUDGET:   space_left_in   = csr_data[30:0];
            CSR_FILTER_BY_TASK: filter_in       = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         fail_percent_ff  <= '0;
         every_nth_ff     <= 32'd1;
         filter_ff        <= 1'b0;
         failures_left_ff <= 32'd1;
         space_left_ff    <= '0;
         counter_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         fail_percent_ff  <= fail_percent_in;
         every_nth_ff     <= every_nth_in;
         filter_ff        <= filter_in;
         failures_left_ff <= failures_left_in;
         space_left_ff    <= space_left_in;
         counter_ff       <= counter_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_fault_ff <= rsp_fault_in;
      result_ff    <= result_in;
      // random_word mod 100: low quotient bits, then remainder modulo 128
      rnd_quot_ff  <= 7'((64'(rnd_ff) * 64'(PERCENT_RECIP)) >> PERCENT_SHIFT);
      rnd_mod_ff   <= rnd_ff[6:0] - rnd_quot_ff * PERCENT_BASE[6:0];
      if (req_accept) begin
         size_ff     <= req_request_size;
         eligible_ff <= req_caller_eligible;
         irq_ff      <= req_from_interrupt;
         rnd_ff      <= req_random_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inject_fault = rsp_fault_ff;

`ifndef SYNTH
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_CHECK))
      else $error("accepted request did not enter check");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> (state_ff == ST_WAIT_CNT))
      else $error("remainder finished outside a wait state");

   a_unit_idle_outside_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FINISH) |-> !rem_status.busy)
      else $error("remainder unit busy while no request in work");

   a_budget_stable_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !csr_write) |=> $stable(failures_left_ff))
      else $error("failure budget changed while idle");
`endif

endmodule
